/* rtl/core/sha_pkg.sv */
`timescale 1ns / 1ps
package sha_pkg;
    typedef enum logic [1:0] {
        FUNC_ABSORB = 2'd0,
        FUNC_ABSORB_FINISH = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } t_comp_ctl;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage

/* rtl/core/sha_if.sv */
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] data_byte;
    modport source(output valid, output func, output data_byte, input ready);
    modport sink(input valid, input func, input data_byte, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source(output valid, output digest_word, output word_index, output last_word,
                   input ready);
    modport sink(input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

/* rtl/core/sha_round.sv */
`timescale 1ns / 1ps
// Compression engine: one round per cycle over a 16-word rolling schedule.
module sha_round (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  logic [511:0] i_block,
    input  logic [255:0] i_h,
    output logic [255:0] o_h
);
    import sha_pkg::*;

    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [5:0]  r_rnd;
    logic        r_busy;
    logic        r_done;
    logic [31:0] w_cur, w_new, t1, t2, s0, s1;

    always_comb begin
        w_cur = r_w[0];
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        t1 = r_v[7] + (rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25))
           + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + RK[r_rnd] + w_cur;
        t2 = (rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22))
           + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rnd  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
                for (int i = 0; i < 16; i++) r_w[i] <= i_block[511 - 32*i -: 32];
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= i_h[255 - 32*i -: 32];
                    r_h[i] <= i_h[255 - 32*i -: 32];
                end
            end else if (r_busy) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= w_new;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (r_done) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
        end
    end

    // Busy stays high through the cycle that adds the working variables into the hash.
    always_comb begin
        o_busy = r_busy | r_done;
        for (int i = 0; i < 8; i++) o_h[255 - 32*i -: 32] = r_h[i];
    end
endmodule

/* rtl/core/sha256_stream_hasher_top.sv */
`timescale 1ns / 1ps
// Bytes are absorbed back to back; the byte that completes a block holds the input off
// while the shared round unit runs its 64 rounds, one per cycle.
// A finish pads one byte per cycle and then runs the final block or blocks; the eight
// digest words then go out one per cycle as the sink takes them.
// Synchronous active-low reset loads the initial hash and clears the counts.
module sha256_stream_hasher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sha_in_if.sink     i_in,
    sha_out_if.source  o_out
);
    import sha_pkg::*;

    t_state       r_state, n_state;
    logic [31:0]  r_buf [16];
    logic [5:0]   r_fill;
    logic [63:0]  r_bits;
    logic [255:0] r_h;
    logic         r_final, r_second, r_len, r_wait;
    logic [2:0]   r_idx;
    logic         in_acc;
    logic [511:0] blk;
    logic [255:0] eng_h;
    logic         eng_start, eng_busy;

    always_comb
        for (int i = 0; i < 16; i++) blk[511 - 32*i -: 32] = r_buf[i];

    assign eng_start = (r_state == ST_COMP) && !r_wait;

    sha_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(eng_start), .o_busy(eng_busy),
        .i_block(blk), .i_h(r_h), .o_h(eng_h)
    );

    assign i_in.ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign o_out.valid = (r_state == ST_EMIT);
    assign o_out.digest_word = r_h[255 - 32*r_idx -: 32];
    assign o_out.word_index  = r_idx;
    assign o_out.last_word   = (r_idx == 3'd7);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_in.func == FUNC_ABSORB || i_in.func == FUNC_ABSORB_FINISH) begin
                        if (r_fill == 6'd63) n_state = ST_COMP;
                        else if (i_in.func == FUNC_ABSORB_FINISH) n_state = ST_PAD;
                    end else if (i_in.func == FUNC_FINISH) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (r_fill == 6'd63) n_state = ST_COMP;
                else if (r_fill == 6'd55) n_state = ST_LEN;
            end
            ST_LEN:  n_state = ST_COMP;
            ST_COMP: begin
                if (r_wait && !eng_busy) begin
                    if (!r_final) n_state = ST_IDLE;
                    else if (r_len) n_state = ST_EMIT;
                    else n_state = ST_PAD;
                end
            end
            ST_EMIT: if (o_out.ready && r_idx == 3'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0; r_bits <= '0; r_final <= 1'b0; r_second <= 1'b0;
            r_len <= 1'b0; r_wait <= 1'b0; r_idx <= '0;
            for (int i = 0; i < 8; i++) r_h[255 - 32*i -: 32] <= INIT_H[i];
        end else begin
            unique case (r_state)
                ST_IDLE: if (in_acc) begin
                    if (i_in.func == FUNC_ABSORB || i_in.func == FUNC_ABSORB_FINISH) begin
                        r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_in.data_byte;
                        r_fill <= r_fill + 6'd1;
                        r_bits <= r_bits + 64'd8;
                        r_final <= (i_in.func == FUNC_ABSORB_FINISH);
                        r_second <= 1'b0;
                        r_len <= 1'b0;
                    end else if (i_in.func == FUNC_FINISH) begin
                        r_final <= 1'b1;
                        r_second <= 1'b0;
                        r_len <= 1'b0;
                    end
                end
                ST_PAD: begin
                    // The marker byte goes in first; zeros follow until the length field.
                    r_buf[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <=
                        r_second ? 8'h00 : PAD_BYTE;
                    r_fill <= r_fill + 6'd1;
                    r_second <= 1'b1;
                end
                ST_LEN: begin
                    r_buf[14] <= r_bits[63:32];
                    r_buf[15] <= r_bits[31:0];
                    r_len <= 1'b1;
                end
                ST_COMP: begin
                    if (!r_wait) r_wait <= 1'b1;
                    else if (!eng_busy) begin
                        r_wait <= 1'b0;
                        r_h <= eng_h;
                        r_fill <= '0;
                    end
                end
                ST_EMIT: if (o_out.ready) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        r_fill <= '0; r_bits <= '0; r_final <= 1'b0; r_second <= 1'b0;
                        r_len <= 1'b0;
                        for (int i = 0; i < 8; i++) r_h[255 - 32*i -: 32] <= INIT_H[i];
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

/* tb/sv/tb_sha256_stream_hasher_top.sv */
`timescale 1ns / 1ps
module tb_sha256_stream_hasher_top;
    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_digest_word;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sha_in_if  in_if();
    sha_out_if out_if();

    sha256_stream_hasher_top uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state, kept apart from the block.
    logic [31:0]  chain_h [8];
    logic [7:0]   msg_block [64];
    int unsigned  block_fill;
    logic [63:0]  bit_length;

    t_digest_word pending_words[$];
    int           error_count = 0;
    bit           sink_stalls = 1'b1;
    bit           source_gaps = 1'b1;
    longint       cycle_count = 0;

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic run_rounds();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        {a, b, c, d, e, f, g, h} = {chain_h[0], chain_h[1], chain_h[2], chain_h[3],
                                    chain_h[4], chain_h[5], chain_h[6], chain_h[7]};
        for (int i = 0; i < 64; i++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                 + RK[i] + w[i];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
        end
        chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
        chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
    endtask

    task automatic restart_hash();
        for (int i = 0; i < 8; i++) chain_h[i] = INIT_H[i];
        block_fill = 0;
        bit_length = '0;
    endtask

    task automatic predict_digest(input t_func fn, input logic [7:0] b);
        t_digest_word dw;
        if (fn == FUNC_NONE) return;
        if (fn == FUNC_ABSORB || fn == FUNC_ABSORB_FINISH) begin
            msg_block[block_fill] = b;
            block_fill++;
            bit_length += 64'd8;
            if (block_fill == 64) begin
                run_rounds();
                block_fill = 0;
            end
            if (fn == FUNC_ABSORB) return;
        end
        msg_block[block_fill] = PAD_BYTE;
        block_fill++;
        if (block_fill > 56) begin
            while (block_fill < 64) msg_block[block_fill++] = 8'h00;
            run_rounds();
            block_fill = 0;
        end
        while (block_fill < 56) msg_block[block_fill++] = 8'h00;
        for (int i = 0; i < 8; i++) msg_block[63-i] = bit_length[8*i +: 8];
        run_rounds();
        for (int i = 0; i < 8; i++) begin
            dw.digest_word = chain_h[i];
            dw.word_index = 3'(i);
            dw.last_word = (i == 7);
            pending_words.push_back(dw);
        end
        restart_hash();
    endtask

    // Valid stays high after a word is taken; a gap or the drain lowers it.
    task automatic send_word(input t_func fn, input logic [7:0] b);
        if (source_gaps && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.func <= fn;
        in_if.data_byte <= b;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_digest(fn, b);
    endtask

    task automatic send_message(input int len, input bit join_last);
        for (int i = 0; i < len; i++) begin
            if (join_last && i == len - 1)
                send_word(FUNC_ABSORB_FINISH, 8'($urandom));
            else
                send_word(FUNC_ABSORB, 8'($urandom));
        end
        if (!join_last || len == 0) send_word(FUNC_FINISH, 8'($urandom));
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_word(FUNC_FINISH, 8'h00);        // empty message
        send_word(FUNC_ABSORB, 8'h00);
        send_word(FUNC_ABSORB, 8'hff);
        send_word(FUNC_NONE, 8'hff);          // unused code must be ignored
        send_word(FUNC_ABSORB_FINISH, 8'h80);
        send_word(FUNC_NONE, 8'h00);
        send_word(FUNC_ABSORB_FINISH, 8'h61);
        send_word(FUNC_FINISH, 8'hff);
        wait_drained();
    endtask

    // Lengths around the padding boundaries: one block or two.
    task automatic test_pad_boundaries();
        int lens [5] = '{55, 56, 63, 64, 0};
        bit joins [5] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        foreach (lens[i]) send_message(lens[i], joins[i]);
        wait_drained();
    endtask

    task automatic test_random_messages();
        int sent;
        sent = 0;
        while (sent < 36) begin
            int len;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 70) : $urandom_range(0, 12);
            if ($urandom_range(0, 9) == 0) begin
                send_word(FUNC_NONE, 8'($urandom));
                sent++;
            end
            send_message(len, 1'($urandom_range(0, 1)));
            sent += len + 1;
            if (sent > 18) begin
                source_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
        end
        wait_drained();
    endtask

    // Output checker and sink stall driver.
    always @(posedge i_clk) begin
        t_digest_word got;
        t_digest_word want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.digest_word, out_if.word_index, out_if.last_word};
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word %h idx %0d last %0b",
                         $time, got.digest_word, got.word_index, got.last_word);
                error_count++;
            end else begin
                want = pending_words.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %h/%0d/%0b actual %h/%0d/%0b", $time,
                             want.digest_word, want.word_index, want.last_word,
                             got.digest_word, got.word_index, got.last_word);
                    error_count++;
                end
            end
        end
    end

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_stalls && $urandom_range(0, 4) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 400000) begin
            $display("** sha256_stream_hasher_top: FAILED **");
            $finish;
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.func = FUNC_ABSORB;
        in_if.data_byte = 8'h00;
        restart_hash();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_pad_boundaries();
        test_random_messages();
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_words.size() == 0)
            $display("** sha256_stream_hasher_top: PASSED **");
        else
            $display("** sha256_stream_hasher_top: FAILED **");
        $finish;
    end
endmodule
